[design/interval_set_mark_unmark_assert.svh]
// Assertion helpers for the interval set block.
`ifndef INTERVAL_SET_MARK_UNMARK_ASSERT_SVH
`define INTERVAL_SET_MARK_UNMARK_ASSERT_SVH
`ifndef SYNTHESIS
`define ISMU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("interval set assertion failed");
`define ISMU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("interval set assertion failed");
`else
`define ISMU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ISMU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/ismu_pkg.sv]
package ismu_pkg;

    localparam logic [1:0] CMD_MARK   = 2'd0;
    localparam logic [1:0] CMD_UNMARK = 2'd1;
    localparam logic [1:0] CMD_PROBE  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] from_time;
        logic [31:0] to_time;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] changed_length;
        logic        has_marks;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_NEXT, S_RD_A, S_RD_B, S_CALC,
        S_WRITE, S_END, S_WRITE_END, S_COMMIT, S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic set_bad;
        logic rd_odd;
        logic ld_a;
        logic calc;
        logic wr;
        logic end_load;
        logic commit;
    } t_ctl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       bad;
        logic       idx_lt;
        logic       probe_done;
        logic       q_last;
    } t_sts;

endpackage

[design/interval_set_mark_unmark.sv]
// Interval set: keeps a sorted table of disjoint half-open covered ranges and
// runs mark, unmark, probe and clear commands one at a time. A command is
// taken when start is high and busy is low; its single result appears on
// o_res for exactly one cycle with o_strobe high and cannot be held off, so
// the receiver must take it then. Each stored interval costs one step to
// pick the pair, two boundary reads, one classify step and one write step per
// boundary written to the spare table bank (at least one). Check, the final
// insert and the commit are further steps before the result strobe. Clear
// and bad ranges go from the check step straight to the result. Probe stops
// at the first boundary past from_time.
module interval_set_mark_unmark #(
    parameter int MAX_MARKS = 64,
    parameter int TIME_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ismu_pkg::t_in  i_in,
    output logic           busy,
    output logic           o_strobe,
    output ismu_pkg::t_res o_res
);
    import ismu_pkg::*;

    `include "interval_set_mark_unmark_assert.svh"

    t_ctl ctl;
    t_sts sts;

    ismu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (sts),
        .o_ctl    (ctl),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    ismu_dp #(
        .MAX_MARKS (MAX_MARKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_res   (o_res)
    );

    `ISMU_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `ISMU_ASSERT_NXT(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy && !o_strobe)
    `ISMU_ASSERT_IMP(a_strobe_status, i_clk, i_rst_n, o_strobe, o_res.status != 2'd3)
    `ISMU_ASSERT_IMP(a_has_ok, i_clk, i_rst_n, o_strobe && o_res.has_marks,
                     o_res.status == ST_OK && o_res.changed_length == 32'd0)

endmodule

[design/ismu_ctrl.sv]
module ismu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ismu_pkg::t_sts i_sts,
    output ismu_pkg::t_ctl o_ctl,
    output logic          o_busy,
    output logic          o_strobe
);
    import ismu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.cmd == CMD_CLEAR || i_sts.bad) n_state = S_RESP;
                else n_state = S_NEXT;
            end
            S_NEXT:   n_state = i_sts.idx_lt ? S_RD_A : S_END;
            S_RD_A:   n_state = S_RD_B;
            S_RD_B:   n_state = S_CALC;
            S_CALC:   n_state = i_sts.probe_done ? S_RESP : S_WRITE;
            S_WRITE:  if (i_sts.q_last) n_state = S_NEXT;
            S_END: begin
                case (i_sts.cmd)
                    CMD_MARK:  n_state = S_WRITE_END;
                    CMD_PROBE: n_state = S_RESP;
                    default:   n_state = S_COMMIT;
                endcase
            end
            S_WRITE_END: if (i_sts.q_last) n_state = S_COMMIT;
            S_COMMIT: n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl    = '0;
        o_busy   = (r_state != S_IDLE);
        o_strobe = (r_state == S_RESP);
        case (r_state)
            S_IDLE:  o_ctl.load = i_start;
            S_CHECK: begin
                o_ctl.clear   = (i_sts.cmd == CMD_CLEAR);
                o_ctl.set_bad = (i_sts.cmd != CMD_CLEAR) && i_sts.bad;
            end
            S_RD_B: begin
                o_ctl.ld_a   = 1'b1;
                o_ctl.rd_odd = 1'b1;
            end
            S_CALC:      o_ctl.calc = 1'b1;
            S_WRITE:     o_ctl.wr = 1'b1;
            S_END:       o_ctl.end_load = (i_sts.cmd == CMD_MARK);
            S_WRITE_END: o_ctl.wr = 1'b1;
            S_COMMIT:    o_ctl.commit = 1'b1;
            default:     o_ctl = '0;
        endcase
    end

endmodule

[design/ismu_dp.sv]
module ismu_dp #(
    parameter int MAX_MARKS = 64,
    parameter int TIME_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ismu_pkg::t_in  i_in,
    input  ismu_pkg::t_ctl i_ctl,
    output ismu_pkg::t_sts o_sts,
    output ismu_pkg::t_res o_res
);
    import ismu_pkg::*;

    localparam int AW = $clog2(MAX_MARKS);
    localparam int IW = $clog2(MAX_MARKS + 1);
    localparam int WW = $clog2(2 * MAX_MARKS + 3);
    localparam int LW = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef logic [TIME_BITS-1:0] t_time;

    // two banks: the walk reads one and builds the new table in the other
    t_time mem [0:2**(AW+1)-1];
    t_time r_rdata;

    logic [1:0]    r_cmd;
    t_time         r_from, r_to, r_a, r_ms, r_me, r_acc;
    logic          r_placed, r_bank;
    logic [IW-1:0] r_cnt, r_idx;
    logic [WW-1:0] r_wcnt;
    t_time         r_q [0:3];
    logic [2:0]    r_qn;
    logic [1:0]    r_qk;
    logic [1:0]    r_status;
    logic [31:0]   r_len;
    logic          r_has;

    t_time      b, lo, hi, ovl, diff;
    t_time      n_q [0:3];
    logic [2:0] n_qn;
    logic       n_placed, probe_done;
    logic [AW-1:0] raddr;
    logic [LW-1:0] len_ext;

    assign b = r_rdata;
    assign lo = (r_a > r_from) ? r_a : r_from;
    assign hi = (b < r_to) ? b : r_to;
    assign ovl = (hi > lo) ? hi - lo : '0;
    assign probe_done = (r_cmd == CMD_PROBE) && ((r_a > r_from) || (b > r_from));
    assign raddr = i_ctl.rd_odd ? AW'(r_idx + IW'(1)) : r_idx[AW-1:0];
    assign diff = (r_to - r_from) - r_acc;
    assign len_ext = LW'((r_cmd == CMD_MARK) ? diff : r_acc);

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[{r_bank, raddr}];
        if (i_ctl.wr && r_qn != 3'd0 && r_wcnt < WW'(MAX_MARKS)) begin
            mem[{~r_bank, r_wcnt[AW-1:0]}] <= r_q[r_qk];
        end
    end

    // pair classification, up to four boundaries queued per pair
    always_comb begin
        n_q[0] = r_a;
        n_q[1] = b;
        n_q[2] = r_a;
        n_q[3] = b;
        n_qn = 3'd0;
        n_placed = r_placed;
        if (r_cmd == CMD_MARK) begin
            if (b < r_from) begin
                n_qn = 3'd2;
            end else if (r_a > r_to) begin
                if (!r_placed) begin
                    n_q[0] = r_ms;
                    n_q[1] = r_me;
                    n_qn = 3'd4;
                    n_placed = 1'b1;
                end else begin
                    n_qn = 3'd2;
                end
            end
        end else if (r_cmd == CMD_UNMARK) begin
            if (b <= r_from || r_a >= r_to) begin
                n_qn = 3'd2;
            end else if (r_a < r_from) begin
                n_q[1] = r_from;
                n_q[2] = r_to;
                n_qn = (b > r_to) ? 3'd4 : 3'd2;
            end else if (b > r_to) begin
                n_q[0] = r_to;
                n_qn = 3'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_bank <= 1'b0;
        end else begin
            if (i_ctl.clear) r_cnt <= '0;
            if (i_ctl.commit && r_wcnt <= WW'(MAX_MARKS)) begin
                r_cnt  <= IW'(r_wcnt);
                r_bank <= ~r_bank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_in.cmd;
            r_from   <= TIME_BITS'(i_in.from_time);
            r_to     <= TIME_BITS'(i_in.to_time);
            r_ms     <= TIME_BITS'(i_in.from_time);
            r_me     <= TIME_BITS'(i_in.to_time);
            r_acc    <= '0;
            r_placed <= 1'b0;
            r_idx    <= '0;
            r_wcnt   <= '0;
            r_qn     <= '0;
            r_qk     <= '0;
            r_status <= ST_OK;
            r_len    <= '0;
            r_has    <= 1'b0;
        end
        if (i_ctl.set_bad) r_status <= ST_BAD_RANGE;
        if (i_ctl.ld_a) r_a <= r_rdata;
        if (i_ctl.calc) begin
            r_idx <= r_idx + IW'(2);
            r_q   <= n_q;
            r_qn  <= n_qn;
            r_qk  <= '0;
            r_placed <= n_placed;
            if (probe_done) r_has <= (r_a > r_from) ? (r_a < r_to) : 1'b1;
            if (r_cmd == CMD_MARK) begin
                if (!(b < r_from) && !(r_a > r_to)) begin
                    r_acc <= r_acc + ovl;
                    if (r_a < r_ms) r_ms <= r_a;
                    if (b > r_me) r_me <= b;
                end
            end else if (r_cmd == CMD_UNMARK) begin
                r_acc <= r_acc + ovl;
            end
        end
        if (i_ctl.end_load) begin
            r_q[0] <= r_ms;
            r_q[1] <= r_me;
            r_qn   <= r_placed ? 3'd0 : 3'd2;
            r_qk   <= '0;
        end
        if (i_ctl.wr && r_qn != 3'd0) begin
            r_qk   <= r_qk + 2'd1;
            r_wcnt <= r_wcnt + WW'(1);
        end
        if (i_ctl.commit) begin
            if (r_wcnt > WW'(MAX_MARKS)) begin
                r_status <= ST_FULL;
            end else begin
                r_len <= ((len_ext >> 32) != '0) ? 32'hFFFF_FFFF : len_ext[31:0];
            end
        end
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.bad        = (r_from >= r_to);
        o_sts.idx_lt     = (r_idx < r_cnt);
        o_sts.probe_done = probe_done;
        o_sts.q_last     = (r_qn == 3'd0) || ({1'b0, r_qk} == r_qn - 3'd1);
        o_res.status         = r_status;
        o_res.changed_length = r_len;
        o_res.has_marks      = r_has;
    end

endmodule

[tb/sv/interval_set_checker.sv]
module interval_set_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  ismu_pkg::t_in  i_in,
    input  logic           i_strobe,
    input  ismu_pkg::t_res i_res,
    output int             o_fail_count,
    output int             o_pending
);
    import ismu_pkg::*;

    localparam int MAX_MARKS = 64;

    logic [31:0] bnd_time [MAX_MARKS];
    int          bnd_count;
    t_res        expected_results[$];

    assign o_pending = expected_results.size();

    function automatic t_res apply_command(t_in cmd_beat);
        t_res        r;
        logic [31:0] new_time [MAX_MARKS + 2];
        int          n_new;
        logic [31:0] ms, me, a, b, lo, hi;
        logic [32:0] covered;
        bit          placed;
        r = '0;
        n_new = 0;
        covered = '0;
        placed = 0;
        ms = cmd_beat.from_time;
        me = cmd_beat.to_time;
        if (cmd_beat.cmd == CMD_CLEAR) begin
            bnd_count = 0;
            return r;
        end
        if (cmd_beat.from_time >= cmd_beat.to_time) begin
            r.status = ST_BAD_RANGE;
            return r;
        end
        if (cmd_beat.cmd == CMD_PROBE) begin
            for (int i = 0; i < bnd_count; i++) begin
                if (bnd_time[i] > cmd_beat.from_time) begin
                    r.has_marks = (bnd_time[i] < cmd_beat.to_time) || i[0];
                    break;
                end
            end
            return r;
        end
        for (int i = 0; i < bnd_count; i += 2) begin
            a = bnd_time[i];
            b = bnd_time[i + 1];
            lo = (a > cmd_beat.from_time) ? a : cmd_beat.from_time;
            hi = (b < cmd_beat.to_time) ? b : cmd_beat.to_time;
            if (cmd_beat.cmd == CMD_MARK) begin
                if (b < cmd_beat.from_time) begin
                    if (n_new < MAX_MARKS + 2) begin
                        new_time[n_new] = a; new_time[n_new + 1] = b;
                    end
                    n_new += 2;
                end else if (a > cmd_beat.to_time) begin
                    if (!placed) begin
                        if (n_new < MAX_MARKS + 2) begin
                            new_time[n_new] = ms; new_time[n_new + 1] = me;
                        end
                        n_new += 2;
                        placed = 1;
                    end
                    if (n_new < MAX_MARKS + 2) begin
                        new_time[n_new] = a; new_time[n_new + 1] = b;
                    end
                    n_new += 2;
                end else begin
                    if (hi > lo) covered += hi - lo;
                    if (a < ms) ms = a;
                    if (b > me) me = b;
                end
            end else begin
                if (b <= cmd_beat.from_time || a >= cmd_beat.to_time) begin
                    if (n_new < MAX_MARKS + 2) begin
                        new_time[n_new] = a; new_time[n_new + 1] = b;
                    end
                    n_new += 2;
                end else begin
                    if (hi > lo) covered += hi - lo;
                    if (a < cmd_beat.from_time) begin
                        if (n_new < MAX_MARKS + 2) begin
                            new_time[n_new] = a; new_time[n_new + 1] = cmd_beat.from_time;
                        end
                        n_new += 2;
                    end
                    if (b > cmd_beat.to_time) begin
                        if (n_new < MAX_MARKS + 2) begin
                            new_time[n_new] = cmd_beat.to_time; new_time[n_new + 1] = b;
                        end
                        n_new += 2;
                    end
                end
            end
        end
        if (cmd_beat.cmd == CMD_MARK && !placed) begin
            if (n_new < MAX_MARKS + 2) begin
                new_time[n_new] = ms; new_time[n_new + 1] = me;
            end
            n_new += 2;
        end
        if (n_new > MAX_MARKS) begin
            r.status = ST_FULL;
            return r;
        end
        for (int i = 0; i < n_new; i++) bnd_time[i] = new_time[i];
        bnd_count = n_new;
        if (cmd_beat.cmd == CMD_MARK)
            r.changed_length = cmd_beat.to_time - cmd_beat.from_time - covered[31:0];
        else
            r.changed_length = covered[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res exp_res;
        if (!i_rst_n) begin
            bnd_count = 0;
            o_fail_count <= 0;
        end else begin
            // result first: a new command cannot produce its result same cycle
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_res !== exp_res) begin
                        $display("%0t: mismatch expected %p actual %p", $time, exp_res,
                                 i_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results.insert(expected_results.size(), apply_command(i_in));
        end
    end
endmodule

[tb/sv/tb_interval_set_mark_unmark.sv]
module tb_interval_set_mark_unmark;
    import ismu_pkg::*;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    t_in   cmd_beat;
    logic  busy;
    logic  o_strobe;
    t_res  o_res;
    int    fail_count;
    int    pending;
    int    cycle_count;
    int    send_idle_pct;

    interval_set_mark_unmark i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (cmd_beat),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    interval_set_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_in        (cmd_beat),
        .i_strobe    (o_strobe),
        .i_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_cmd(logic [1:0] c, logic [31:0] f, logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        start <= 1'b1;
        cmd_beat <= '{cmd: c, from_time: f, to_time: t};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // small window so ranges overlap, touch and split often
    task automatic send_random(int span);
        logic [31:0] f, t, base;
        int          r;
        r = $urandom_range(99);
        base = ($urandom_range(15) == 0) ? $urandom : 32'h1000;
        f = base + $urandom_range(span);
        t = f + $urandom_range(span / 8) + 1;
        if (r < 4) send_cmd(CMD_CLEAR, $urandom, $urandom);
        else if (r < 8) send_cmd(2'($urandom_range(2)), $urandom, $urandom);
        else if (r < 50) send_cmd(CMD_MARK, f, t);
        else if (r < 80) send_cmd(CMD_UNMARK, f, t);
        else send_cmd(CMD_PROBE, f, t);
    endtask

    initial begin
        cycle_count = 0;
        i_rst_n = 0;
        start = 0;
        cmd_beat = '0;
        send_idle_pct = 15;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_cmd(CMD_PROBE, 0, 32'hFFFF_FFFF);
        send_cmd(CMD_UNMARK, 0, 10);
        send_cmd(CMD_MARK, 0, 32'hFFFF_FFFF);
        send_cmd(CMD_PROBE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_cmd(CMD_UNMARK, 100, 200);
        send_cmd(CMD_MARK, 150, 300);
        send_cmd(CMD_PROBE, 150, 160);
        send_cmd(CMD_MARK, 5, 5);
        send_cmd(CMD_UNMARK, 9, 3);
        send_cmd(CMD_PROBE, 32'hFFFF_FFFF, 0);
        send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_MARK, 10, 20);
        send_cmd(CMD_MARK, 20, 30);
        send_cmd(CMD_MARK, 40, 50);
        send_cmd(CMD_PROBE, 30, 40);
        send_cmd(CMD_PROBE, 29, 31);
        send_cmd(CMD_UNMARK, 15, 45);
        send_cmd(CMD_CLEAR, 0, 0);
        // fill to table full, then one more trim and one more insert
        for (int i = 0; i < 33; i++) send_cmd(CMD_MARK, i * 4, i * 4 + 2);
        send_cmd(CMD_UNMARK, 1, 2);
        send_cmd(CMD_MARK, 1000, 1001);
        send_cmd(CMD_CLEAR, 0, 0);
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 67 : 0;
            for (int i = 0; i < 220; i++) send_random((ph == 1) ? 4000 : 600);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
